// File: rtl/mqtt_packet_deframer_defines.svh
// Assertion macros shared by the deframer RTL
`ifndef MQTT_PACKET_DEFRAMER_DEFINES_SVH
`define MQTT_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low
`define MPD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low
`define MPD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mpd_pkg.sv
// Types and constants of the MQTT packet deframer
package mpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int TYPE_W  = 4;
    localparam int LEN_W   = 28;
    localparam int TLEN_W  = 16;
    localparam int DIGIT_W = 7;
    localparam int CNT_W   = 2;
    localparam int SHIFT_W = 5;

    // Packet type code of PUBLISH (high nibble of 0x30)
    localparam logic [TYPE_W-1:0] PUBLISH_TYPE = 4'h3;
    // Bit position of the continuation flag in a length digit
    localparam int CONT_BIT = 7;
    // Bit weight of one base-128 digit
    localparam logic [SHIFT_W-1:0] DIGIT_SHIFT = 5'd7;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TLEN_HI = 3'd2,
        PH_TLEN_LO = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_IGNORE  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_TYPE    = 3'd0,
        KIND_LENGTH  = 3'd1,
        KIND_TLEN    = 3'd2,
        KIND_TOPIC   = 3'd3,
        KIND_PAYLOAD = 3'd4,
        KIND_IGNORE  = 3'd5
    } byte_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        byte_kind_t        byte_kind;
        logic [TYPE_W-1:0] packet_type;
        logic [LEN_W-1:0]  body_length;
        logic [TLEN_W-1:0] topic_length;
        logic              end_of_packet;
        logic              malformed;
        logic              publish_dropped;
    } result_t;

endpackage

// File: rtl/mpd_parser.sv
// Parse state and per-word classification of the deframer
`include "mqtt_packet_deframer_defines.svh"

module mpd_parser #(
    parameter int LENGTH_DIGITS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        take,
    input  logic [mpd_pkg::BYTE_W-1:0]  rx_byte,
    output mpd_pkg::result_t            result
);

    mpd_pkg::phase_t                  phase_reg, phase_next;
    logic [mpd_pkg::TYPE_W-1:0]       type_reg, type_next;
    logic [mpd_pkg::LEN_W-1:0]        accum_reg, accum_next;
    logic [mpd_pkg::CNT_W-1:0]        digit_reg, digit_next;
    logic [mpd_pkg::LEN_W-1:0]        left_reg, left_next;
    logic [mpd_pkg::TLEN_W-1:0]       tlen_reg, tlen_next;
    logic [mpd_pkg::TLEN_W-1:0]       tleft_reg, tleft_next;
    logic                             drop_reg, drop_next;

    logic [mpd_pkg::SHIFT_W-1:0]      digit_shift;
    logic [mpd_pkg::LEN_W-1:0]        digit_val;
    logic [mpd_pkg::LEN_W-1:0]        accum_sum;
    logic                             digit_last;
    logic                             cont;
    logic [mpd_pkg::LEN_W-1:0]        left_dec;
    logic [mpd_pkg::TLEN_W-1:0]       tlen_full;
    logic [mpd_pkg::TLEN_W-1:0]       tleft_dec;

    mpd_pkg::byte_kind_t              kind;
    logic                             eop;
    logic                             bad;

    // Shared arithmetic on the current state
    always_comb begin
        digit_shift = mpd_pkg::SHIFT_W'(digit_reg) * mpd_pkg::DIGIT_SHIFT;
        digit_val   = mpd_pkg::LEN_W'(rx_byte[mpd_pkg::DIGIT_W-1:0]) << digit_shift;
        accum_sum   = accum_reg + digit_val;
        cont        = rx_byte[mpd_pkg::CONT_BIT];
        digit_last  = ({1'b0, digit_reg} + 3'd1) >= 3'(LENGTH_DIGITS);
        left_dec    = left_reg - mpd_pkg::LEN_W'(1);
        tlen_full   = tlen_reg | mpd_pkg::TLEN_W'(rx_byte);
        tleft_dec   = tleft_reg - mpd_pkg::TLEN_W'(1);
    end

    // Next phase and counters
    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        accum_next = accum_reg;
        digit_next = digit_reg;
        left_next  = left_reg;
        tlen_next  = tlen_reg;
        tleft_next = tleft_reg;
        drop_next  = drop_reg;
        unique case (phase_reg)
            mpd_pkg::PH_LENGTH: begin
                accum_next = accum_sum;
                if (cont) begin
                    if (digit_last) begin
                        phase_next = mpd_pkg::PH_HEADER;
                    end else begin
                        digit_next = digit_reg + mpd_pkg::CNT_W'(1);
                    end
                end else begin
                    left_next = accum_sum;
                    if (type_reg == mpd_pkg::PUBLISH_TYPE &&
                        accum_sum < mpd_pkg::LEN_W'(2)) begin
                        drop_next = 1'b1;
                    end
                    if (accum_sum == '0) begin
                        phase_next = mpd_pkg::PH_HEADER;
                    end else if (type_reg == mpd_pkg::PUBLISH_TYPE &&
                                 accum_sum >= mpd_pkg::LEN_W'(2)) begin
                        phase_next = mpd_pkg::PH_TLEN_HI;
                    end else begin
                        phase_next = mpd_pkg::PH_IGNORE;
                    end
                end
            end
            mpd_pkg::PH_TLEN_HI: begin
                tlen_next  = {rx_byte, 8'h00};
                left_next  = left_dec;
                phase_next = mpd_pkg::PH_TLEN_LO;
            end
            mpd_pkg::PH_TLEN_LO: begin
                tlen_next  = tlen_full;
                tleft_next = tlen_full;
                left_next  = left_dec;
                if (left_dec == '0) begin
                    phase_next = mpd_pkg::PH_HEADER;
                    if (tlen_full != '0) begin
                        drop_next = 1'b1;
                    end
                end else if (left_dec < mpd_pkg::LEN_W'(tlen_full)) begin
                    drop_next  = 1'b1;
                    phase_next = mpd_pkg::PH_IGNORE;
                end else if (tlen_full != '0) begin
                    phase_next = mpd_pkg::PH_TOPIC;
                end else begin
                    phase_next = mpd_pkg::PH_PAYLOAD;
                end
            end
            mpd_pkg::PH_TOPIC: begin
                tleft_next = tleft_dec;
                left_next  = left_dec;
                if (left_dec == '0) begin
                    phase_next = mpd_pkg::PH_HEADER;
                end else if (tleft_dec == '0) begin
                    phase_next = mpd_pkg::PH_PAYLOAD;
                end
            end
            mpd_pkg::PH_PAYLOAD, mpd_pkg::PH_IGNORE: begin
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = mpd_pkg::PH_HEADER;
                end
            end
            default: begin
                // Header byte, also taken for any stray phase code
                type_next  = rx_byte[mpd_pkg::BYTE_W-1 -: mpd_pkg::TYPE_W];
                accum_next = '0;
                digit_next = '0;
                left_next  = '0;
                tlen_next  = '0;
                tleft_next = '0;
                drop_next  = 1'b0;
                phase_next = mpd_pkg::PH_LENGTH;
            end
        endcase
    end

    // Classify the word and flag packet end and bad length
    always_comb begin
        kind = mpd_pkg::KIND_TYPE;
        eop  = 1'b0;
        bad  = 1'b0;
        unique case (phase_reg)
            mpd_pkg::PH_LENGTH: begin
                kind = mpd_pkg::KIND_LENGTH;
                eop  = !cont && (accum_sum == '0);
                bad  = cont && digit_last;
            end
            mpd_pkg::PH_TLEN_HI: begin
                kind = mpd_pkg::KIND_TLEN;
            end
            mpd_pkg::PH_TLEN_LO: begin
                kind = mpd_pkg::KIND_TLEN;
                eop  = (left_dec == '0);
            end
            mpd_pkg::PH_TOPIC: begin
                kind = mpd_pkg::KIND_TOPIC;
                eop  = (left_dec == '0);
            end
            mpd_pkg::PH_PAYLOAD: begin
                kind = mpd_pkg::KIND_PAYLOAD;
                eop  = (left_dec == '0);
            end
            mpd_pkg::PH_IGNORE: begin
                kind = mpd_pkg::KIND_IGNORE;
                eop  = (left_dec == '0);
            end
            default: begin
                kind = mpd_pkg::KIND_TYPE;
            end
        endcase
    end

    // Pack the result from the updated state
    always_comb begin
        result.data_byte       = rx_byte;
        result.byte_kind       = kind;
        result.packet_type     = type_next;
        result.body_length     = accum_next;
        result.topic_length    = tlen_next;
        result.end_of_packet   = eop;
        result.malformed       = bad;
        result.publish_dropped = drop_next;
    end

    // Advance the parse state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mpd_pkg::PH_HEADER;
            type_reg  <= '0;
            accum_reg <= '0;
            digit_reg <= '0;
            left_reg  <= '0;
            tlen_reg  <= '0;
            tleft_reg <= '0;
            drop_reg  <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            accum_reg <= accum_next;
            digit_reg <= digit_next;
            left_reg  <= left_next;
            tlen_reg  <= tlen_next;
            tleft_reg <= tleft_next;
            drop_reg  <= drop_next;
        end
    end

    `MPD_ASSERT_NXT(a_header_starts_length, take && phase_reg == mpd_pkg::PH_HEADER, phase_reg == mpd_pkg::PH_LENGTH && accum_reg == '0 && digit_reg == '0, "header word did not restart length decode")
    `MPD_ASSERT_IMP(a_body_left_nonzero, phase_reg == mpd_pkg::PH_TOPIC || phase_reg == mpd_pkg::PH_PAYLOAD || phase_reg == mpd_pkg::PH_IGNORE, left_reg != '0, "body phase with no bytes left")
    `MPD_ASSERT_IMP(a_topic_fits_body, phase_reg == mpd_pkg::PH_TOPIC, mpd_pkg::LEN_W'(tleft_reg) <= left_reg, "topic runs past the body")
    `MPD_ASSERT_IMP(a_digit_in_range, phase_reg == mpd_pkg::PH_LENGTH, 32'(digit_reg) < LENGTH_DIGITS, "length digit count out of range")

endmodule

// File: rtl/mqtt_packet_deframer.sv
// Each accepted word's result is registered and appears on m_* in the cycle after it is accepted.
// Throughput: one word per cycle; s_ready drops only while a result is held
// in the output register and m_ready is low.
// The parse state machine and its counters update once per accepted word.
// Reset (aresetn low, synchronous) clears the parse state to expect a header
// byte and empties the output register.
`include "mqtt_packet_deframer_defines.svh"

module mqtt_packet_deframer #(
    parameter int LENGTH_DIGITS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mpd_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mpd_pkg::BYTE_W-1:0]  m_data_byte,
    output logic [2:0]                  m_byte_kind,
    output logic [mpd_pkg::TYPE_W-1:0]  m_packet_type,
    output logic [mpd_pkg::LEN_W-1:0]   m_body_length,
    output logic [mpd_pkg::TLEN_W-1:0]  m_topic_length,
    output logic                        m_end_of_packet,
    output logic                        m_malformed,
    output logic                        m_publish_dropped
);

    logic               take;
    mpd_pkg::result_t   result;
    mpd_pkg::result_t   res_reg;
    logic               valid_reg;

    // Accept whenever the output register is empty or drains this cycle
    assign s_ready = !valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    mpd_parser #(
        .LENGTH_DIGITS (LENGTH_DIGITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .rx_byte (s_rx_byte),
        .result  (result)
    );

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= result;
        end
    end

    assign m_valid           = valid_reg;
    assign m_data_byte       = res_reg.data_byte;
    assign m_byte_kind       = res_reg.byte_kind;
    assign m_packet_type     = res_reg.packet_type;
    assign m_body_length     = res_reg.body_length;
    assign m_topic_length    = res_reg.topic_length;
    assign m_end_of_packet   = res_reg.end_of_packet;
    assign m_malformed       = res_reg.malformed;
    assign m_publish_dropped = res_reg.publish_dropped;

    `MPD_ASSERT_IMP(a_malformed_on_digit, valid_reg && res_reg.malformed, res_reg.byte_kind == mpd_pkg::KIND_LENGTH && !res_reg.end_of_packet, "malformed flag off a length digit")
    `MPD_ASSERT_IMP(a_dropped_no_payload, valid_reg && res_reg.publish_dropped, res_reg.byte_kind != mpd_pkg::KIND_TOPIC && res_reg.byte_kind != mpd_pkg::KIND_PAYLOAD, "dropped packet still delivers topic or payload")
    `MPD_ASSERT_IMP(a_type_clears_lengths, valid_reg && res_reg.byte_kind == mpd_pkg::KIND_TYPE, res_reg.body_length == '0 && res_reg.topic_length == '0 && !res_reg.end_of_packet, "header word carries stale lengths")

endmodule
